// ===== rtl/core/qsfe_pkg.sv =====
// Shared types, codes and saturating fixed-point helpers for the quadratic spline block.
package qsfe_pkg;

  localparam int MAX_NODES_DEF = 256;
  localparam int PORT_FRAC_DEF = 16;
  localparam int CFG_W         = 9;

  typedef logic signed [63:0] fx_t;

  localparam fx_t FX_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fx_t FX_MIN   = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;
  localparam fx_t FX32_MAX = 64'sd2147483647;
  localparam fx_t FX32_MIN = -64'sd2147483648;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_EVAL  = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FEW     = 2'd1;
  localparam logic [1:0] STATUS_DIV0    = 2'd2;
  localparam logic [1:0] STATUS_UNBUILT = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         node_index;
    logic signed [31:0] node_pos;
    logic signed [31:0] node_val;
    logic signed [31:0] query_pos;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic mul_go;
    logic div_go;
    fx_t  op_a;
    fx_t  op_b;
  } arith_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
    fx_t  result;
  } arith_rsp_t;

  function automatic fx_t sat_add(input fx_t a, input fx_t b);
    fx_t r;
    r = a + b;
    if ((a[63] == b[63]) && (r[63] != a[63])) return a[63] ? FX_MIN : FX_MAX;
    return r;
  endfunction

  function automatic fx_t sat_sub(input fx_t a, input fx_t b);
    fx_t r;
    r = a - b;
    if ((a[63] != b[63]) && (r[63] != a[63])) return a[63] ? FX_MIN : FX_MAX;
    return r;
  endfunction

  function automatic fx_t sat_neg(input fx_t a);
    return (a == FX_MIN) ? FX_MAX : -a;
  endfunction

  function automatic logic [63:0] magnitude(input fx_t a);
    return a[63] ? (64'd0 - 64'(a)) : 64'(a);
  endfunction

  // Puts the sign back on an unsigned magnitude and saturates.
  function automatic fx_t apply_sign(input logic [63:0] q, input logic neg, input logic ovf);
    if (neg) begin
      if (ovf || (q > 64'h8000_0000_0000_0000)) return FX_MIN;
      return fx_t'(64'd0 - q);
    end
    if (ovf || q[63]) return FX_MAX;
    return fx_t'(q);
  endfunction

endpackage

// ===== rtl/core/qsfe_arith.sv =====
// Shared multi-cycle Q32.32 multiplier and restoring divider for the spline block.
module qsfe_arith (
  input  logic                 clk,
  input  logic                 rst,
  input  qsfe_pkg::arith_req_t req,
  output qsfe_pkg::arith_rsp_t rsp
);
  import qsfe_pkg::*;

  logic [63:0]  ua, ub;
  logic         sneg;
  logic         mbusy, dbusy, dfin;
  logic [2:0]   mcnt;
  logic [6:0]   dcnt;
  logic [63:0]  pp;
  logic [1:0]   psh;
  logic [127:0] acc;
  logic [95:0]  dvd;
  logic [64:0]  rem;
  logic [63:0]  dq;
  logic         dovf;
  logic         done_r, zero_r;
  fx_t          result;

  logic [31:0]  ma, mb;
  logic [1:0]   sh_sel;
  logic [63:0]  mprod;
  logic [127:0] pp_ext;
  logic [64:0]  remsh;
  logic         ge;

  // The four 32x32 partial products, one per cycle.
  always_comb begin
    case (mcnt)
      3'd0: begin
        ma = ua[31:0];  mb = ub[31:0];  sh_sel = 2'd0;
      end
      3'd1: begin
        ma = ua[31:0];  mb = ub[63:32]; sh_sel = 2'd1;
      end
      3'd2: begin
        ma = ua[63:32]; mb = ub[31:0];  sh_sel = 2'd1;
      end
      default: begin
        ma = ua[63:32]; mb = ub[63:32]; sh_sel = 2'd2;
      end
    endcase
    mprod = 64'(ma) * 64'(mb);
    case (psh)
      2'd0:    pp_ext = {64'd0, pp};
      2'd1:    pp_ext = {32'd0, pp, 32'd0};
      default: pp_ext = {pp, 64'd0};
    endcase
    remsh = {rem[63:0], dvd[95]};
    ge    = remsh >= {1'b0, ub};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy  <= 1'b0;
      dbusy  <= 1'b0;
      dfin   <= 1'b0;
      done_r <= 1'b0;
      zero_r <= 1'b0;
      mcnt   <= '0;
      dcnt   <= '0;
    end else begin
      done_r <= 1'b0;
      zero_r <= 1'b0;
      if (req.mul_go) begin
        ua    <= magnitude(req.op_a);
        ub    <= magnitude(req.op_b);
        sneg  <= req.op_a[63] ^ req.op_b[63];
        acc   <= '0;
        mcnt  <= '0;
        mbusy <= 1'b1;
      end else if (mbusy) begin
        if (mcnt <= 3'd3) begin
          pp  <= mprod;
          psh <= sh_sel;
        end
        if ((mcnt != 3'd0) && (mcnt <= 3'd4)) acc <= acc + pp_ext;
        if (mcnt == 3'd5) begin
          result <= apply_sign(acc[95:32], sneg, |acc[127:96]);
          done_r <= 1'b1;
          mbusy  <= 1'b0;
        end
        mcnt <= mcnt + 3'd1;
      end
      if (req.div_go) begin
        if (req.op_b == '0) begin
          result <= '0;
          done_r <= 1'b1;
          zero_r <= 1'b1;
        end else begin
          dvd   <= {magnitude(req.op_a), 32'd0};
          ub    <= magnitude(req.op_b);
          sneg  <= req.op_a[63] ^ req.op_b[63];
          rem   <= '0;
          dq    <= '0;
          dovf  <= 1'b0;
          dcnt  <= '0;
          dbusy <= 1'b1;
        end
      end else if (dbusy) begin
        if (dq[63]) dovf <= 1'b1;
        if (ge) begin
          rem <= remsh - {1'b0, ub};
          dq  <= {dq[62:0], 1'b1};
        end else begin
          rem <= remsh;
          dq  <= {dq[62:0], 1'b0};
        end
        dvd  <= {dvd[94:0], 1'b0};
        dcnt <= dcnt + 7'd1;
        if (dcnt == 7'd95) begin
          dbusy <= 1'b0;
          dfin  <= 1'b1;
        end
      end else if (dfin) begin
        result <= apply_sign(dq, sneg, dovf);
        done_r <= 1'b1;
        dfin   <= 1'b0;
      end
    end
  end

  assign rsp = '{done: done_r, div_zero: zero_r, result: result};

endmodule

// ===== rtl/core/quadratic_spline_fit_eval.sv =====
// Quadratic spline fit and evaluation: node load, coefficient build and query.
// A load transfer gives no result. A query runs the search reads and three
// multiplies, and a build leans on the 96-step shared divider for each node.
// Synchronous reset clears node_count, the built flag and the handshakes; the
// memories are not cleared and hold whatever was last written.
module quadratic_spline_fit_eval #(
  parameter int MAX_NODES      = qsfe_pkg::MAX_NODES_DEF,
  parameter int PORT_FRAC_BITS = qsfe_pkg::PORT_FRAC_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [qsfe_pkg::CFG_W-1:0] cfg_write_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  qsfe_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output qsfe_pkg::out_item_t        out_data
);
  import qsfe_pkg::*;

  localparam int IW    = $clog2(MAX_NODES + 1);
  localparam int AW    = $clog2(MAX_NODES);
  localparam int SCALE = 32 - PORT_FRAC_BITS;
  localparam logic [IW-1:0] ONE = IW'(1);

  typedef enum logic [6:0] {
    ST_IDLE, ST_OUT, ST_WOP,
    ST_L1_R0, ST_L1_R1, ST_L1_R2, ST_L1_R3, ST_L1_E, ST_L1_K, ST_L1_U,
    ST_L1_M1, ST_L1_M2, ST_L1_D, ST_L1_Z0, ST_L1_Z1, ST_L1_NX,
    ST_L2_R0, ST_L2_R1, ST_L2_R2,
    ST_L2_A0, ST_L2_A1, ST_L2_A2, ST_L2_A3, ST_L2_A4, ST_L2_A5, ST_L2_A6, ST_L2_A7,
    ST_L2_A8, ST_L2_A9, ST_L2_A10, ST_L2_A11, ST_L2_A12, ST_L2_A13, ST_L2_A14,
    ST_L2_E0, ST_L2_E1, ST_L2_M0, ST_L2_M1, ST_L2_M2, ST_L2_M3, ST_L2_W,
    ST_L2_F0, ST_L2_F1,
    ST_L3_R0, ST_L3_R1, ST_L3_A, ST_L3_B,
    ST_L4_R0, ST_L4_R1, ST_L4_R2, ST_L4_P,
    ST_L4_A0, ST_L4_A1, ST_L4_A2, ST_L4_A3, ST_L4_A4, ST_L4_A5, ST_L4_A6, ST_L4_A7,
    ST_L4_A8, ST_FIN,
    ST_Q_R0, ST_Q_R1, ST_Q_R2, ST_S_CHK, ST_S_CMP, ST_S_SP0, ST_S_SP1, ST_S_SP2,
    ST_E_R0, ST_E_R1, ST_E_DX, ST_E_M0, ST_E_M1, ST_E_M2, ST_E_M3, ST_E_S, ST_E_O
  } state_t;

  function automatic fx_t to_fx(input logic [31:0] r);
    return fx_t'({{32{r[31]}}, r}) <<< SCALE;
  endfunction

  state_t state, ret_state;

  // Control state.
  logic [CFG_W-1:0] node_count;
  logic             built, fault;
  logic [IW-1:0]    idx, lo, hi;

  // Shared arithmetic unit.
  logic       mul_go, div_go;
  fx_t        op_a, op_b;
  arith_req_t areq;
  arith_rsp_t arsp;

  // Datapath registers.
  fx_t pp, pc, pn, ext0, extn, knot_l, knot_r, uu, ww;
  fx_t val_l, val_r, u_l, w_l, d_l, u_r, w_r, d_r;
  fx_t diag_p, upper_p, rhs_p, rhs_n;
  fx_t ca, cb, kl, kr, lo_c, dg, up, rr, t1, t2, d0, d1, xr, tq, dx, res;
  fx_t sh_out;
  logic signed [31:0] res_value;
  logic [1:0]         res_status;

  // Active node count and derived indexes.
  logic [31:0]   ncnt32;
  logic [IW-1:0] nact, nm1;
  logic [IW:0]   mid_sum;
  logic [IW-1:0] mid;
  logic          in_xfer, load_ok;

  assign ncnt32  = (32'(node_count) > 32'(MAX_NODES)) ? 32'(MAX_NODES) : 32'(node_count);
  assign nact    = ncnt32[IW-1:0];
  assign nm1     = nact - ONE;
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[IW:1];
  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign load_ok  = 32'(in_data.node_index) < 32'(MAX_NODES);
  assign sh_out   = rr >>> SCALE;

  assign areq = '{mul_go: mul_go, div_go: div_go, op_a: op_a, op_b: op_b};

  qsfe_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (areq),
    .rsp (arsp)
  );

  // Memories: one shared read address, one shared write address, registered read data.
  logic [31:0]   pos_mem   [MAX_NODES];
  logic [31:0]   val_mem   [MAX_NODES];
  fx_t           u_mem     [MAX_NODES];
  fx_t           w_mem     [MAX_NODES];
  fx_t           d_mem     [MAX_NODES];
  fx_t           lin_mem   [MAX_NODES];
  fx_t           quad_mem  [MAX_NODES];
  fx_t           diag_mem  [MAX_NODES + 1];
  fx_t           upper_mem [MAX_NODES + 1];
  fx_t           rhs_mem   [MAX_NODES + 1];

  logic [31:0]   pos_q, val_q;
  fx_t           u_q, w_q, d_q, lin_q, quad_q, diag_q, upper_q, rhs_q;
  logic [IW-1:0] ra, wa;
  logic          we_node, we_uw, we_d, we_diag, we_upper, we_rhs, we_lin, we_quad;
  fx_t           wd_diag, wd_upper, wd_rhs;

  always_comb begin
    case (state)
      ST_L1_R0: ra = (idx == '0) ? '0 : idx - ONE;
      ST_L1_R1: ra = idx;
      ST_L1_R2: ra = (idx == nm1) ? idx : idx + ONE;
      ST_L2_R0: ra = idx - ONE;
      ST_L2_R1: ra = (idx == nact) ? idx - ONE : idx;
      ST_L3_R0: ra = idx;
      ST_L4_R0: ra = idx;
      ST_L4_R1: ra = idx + ONE;
      ST_Q_R0:  ra = '0;
      ST_Q_R1:  ra = nm1;
      ST_S_CHK: ra = mid;
      ST_S_SP0: ra = lo;
      ST_S_SP1: ra = lo + ONE;
      ST_E_R0:  ra = idx;
      default:  ra = '0;
    endcase
  end

  always_comb begin
    wa       = (state == ST_IDLE) ? IW'(in_data.node_index) : idx;
    we_node  = (state == ST_IDLE) && in_xfer && (in_data.mode == MODE_LOAD) && load_ok;
    we_uw    = (state == ST_L1_M1);
    we_d     = (state == ST_L1_D);
    we_diag  = 1'b0;
    we_upper = 1'b0;
    we_rhs   = 1'b0;
    we_lin   = (state == ST_L4_A5);
    we_quad  = (state == ST_L4_A8);
    wd_diag  = dg;
    wd_upper = up;
    wd_rhs   = res;
    case (state)
      ST_L1_Z0: begin
        we_diag  = 1'b1;
        we_upper = 1'b1;
        wd_diag  = sat_neg(ww);
        wd_upper = uu;
      end
      ST_L1_Z1: we_rhs = 1'b1;
      ST_L2_W: begin
        we_diag  = 1'b1;
        we_upper = 1'b1;
        we_rhs   = 1'b1;
        wd_rhs   = rr;
      end
      ST_L2_F0: begin
        we_diag  = 1'b1;
        we_upper = 1'b1;
      end
      ST_L2_F1: we_rhs = 1'b1;
      ST_L3_B:  we_rhs = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_node) begin
      pos_mem[wa[AW-1:0]] <= in_data.node_pos;
      val_mem[wa[AW-1:0]] <= in_data.node_val;
    end
    pos_q <= pos_mem[ra[AW-1:0]];
    val_q <= val_mem[ra[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we_uw) begin
      u_mem[wa[AW-1:0]] <= uu;
      w_mem[wa[AW-1:0]] <= ww;
    end
    if (we_d) d_mem[wa[AW-1:0]] <= res;
    u_q <= u_mem[ra[AW-1:0]];
    w_q <= w_mem[ra[AW-1:0]];
    d_q <= d_mem[ra[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we_lin)  lin_mem[wa[AW-1:0]]  <= res;
    if (we_quad) quad_mem[wa[AW-1:0]] <= res;
    lin_q  <= lin_mem[ra[AW-1:0]];
    quad_q <= quad_mem[ra[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we_diag)  diag_mem[wa]  <= wd_diag;
    if (we_upper) upper_mem[wa] <= wd_upper;
    if (we_rhs)   rhs_mem[wa]   <= wd_rhs;
    diag_q  <= diag_mem[ra];
    upper_q <= upper_mem[ra];
    rhs_q   <= rhs_mem[ra];
  end

  // Sequencer. Each arithmetic step loads the operands, pulses a start and parks
  // in ST_WOP until the unit answers; the answer lands in res for the next step.
  // The start pulse is dropped again on the first cycle in ST_WOP.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ret_state  <= ST_IDLE;
      node_count <= '0;
      built      <= 1'b0;
      fault      <= 1'b0;
      idx        <= '0;
      lo         <= '0;
      hi         <= '0;
      mul_go     <= 1'b0;
      div_go     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_OUT)) out_valid <= 1'b0;
      if (cfg_write_en) begin
        node_count <= cfg_write_data;
        built      <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            res_value <= '0;
            case (in_data.mode)
              MODE_LOAD: begin
                if (load_ok) built <= 1'b0;
              end
              MODE_BUILD: begin
                built <= 1'b0;
                if (ncnt32 < 32'd3) begin
                  res_status <= STATUS_FEW;
                  state      <= ST_OUT;
                end else begin
                  fault <= 1'b0;
                  idx   <= '0;
                  state <= ST_L1_R0;
                end
              end
              MODE_EVAL: begin
                if (ncnt32 < 32'd3) begin
                  res_status <= STATUS_FEW;
                  state      <= ST_OUT;
                end else if (!built) begin
                  res_status <= STATUS_UNBUILT;
                  state      <= ST_OUT;
                end else begin
                  tq    <= to_fx(in_data.query_pos);
                  state <= ST_Q_R0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_data  <= '{value: res_value, status: res_status};
            state     <= ST_IDLE;
          end
        end
        ST_WOP: begin
          mul_go <= 1'b0;
          div_go <= 1'b0;
          if (arsp.done) begin
            res <= arsp.result;
            if (arsp.div_zero) fault <= 1'b1;
            state <= ret_state;
          end
        end

        // Pass one: knots, spans and span products for every node, plus the first system row.
        ST_L1_R0: state <= ST_L1_R1;
        ST_L1_R1: begin
          pp    <= to_fx(pos_q);
          state <= ST_L1_R2;
        end
        ST_L1_R2: begin
          pc    <= to_fx(pos_q);
          val_l <= to_fx(val_q);
          state <= ST_L1_R3;
        end
        ST_L1_R3: begin
          pn    <= to_fx(pos_q);
          state <= ST_L1_E;
        end
        ST_L1_E: begin
          ext0  <= sat_sub(pc, sat_sub(pn, pc));
          extn  <= sat_add(pc, sat_sub(pc, pp));
          state <= ST_L1_K;
        end
        ST_L1_K: begin
          knot_l <= (idx == '0)  ? (sat_add(ext0, pc) >>> 1) : (sat_add(pp, pc) >>> 1);
          knot_r <= (idx == nm1) ? (sat_add(pc, extn) >>> 1) : (sat_add(pc, pn) >>> 1);
          state  <= ST_L1_U;
        end
        ST_L1_U: begin
          uu    <= sat_sub(knot_l, pc);
          ww    <= sat_sub(knot_r, pc);
          state <= ST_L1_M1;
        end
        ST_L1_M1: begin
          op_a <= uu; op_b <= ww; mul_go <= 1'b1;
          ret_state <= ST_L1_M2; state <= ST_WOP;
        end
        ST_L1_M2: begin
          op_a <= res; op_b <= sat_sub(ww, uu); mul_go <= 1'b1;
          ret_state <= ST_L1_D; state <= ST_WOP;
        end
        ST_L1_D: state <= (idx == '0) ? ST_L1_Z0 : ST_L1_NX;
        ST_L1_Z0: begin
          op_a <= val_l; op_b <= sat_sub(uu, ww); mul_go <= 1'b1;
          ret_state <= ST_L1_Z1; state <= ST_WOP;
        end
        ST_L1_Z1: state <= ST_L1_NX;
        ST_L1_NX: begin
          if (idx == nm1) begin
            idx   <= ONE;
            state <= ST_L2_R0;
          end else begin
            idx   <= idx + ONE;
            state <= ST_L1_R0;
          end
        end

        // Pass two: rows of the tridiagonal system and forward elimination.
        ST_L2_R0: state <= ST_L2_R1;
        ST_L2_R1: begin
          u_l <= u_q; w_l <= w_q; d_l <= d_q;
          val_l   <= to_fx(val_q);
          diag_p  <= diag_q;
          upper_p <= upper_q;
          rhs_p   <= rhs_q;
          state   <= ST_L2_R2;
        end
        ST_L2_R2: begin
          u_r <= u_q; w_r <= w_q; d_r <= d_q;
          val_r <= to_fx(val_q);
          state <= (idx == nact) ? ST_L2_E0 : ST_L2_A0;
        end
        ST_L2_A0: begin
          op_a <= u_l; op_b <= sat_sub(sat_add(w_l, w_l), u_l); mul_go <= 1'b1;
          ret_state <= ST_L2_A1; state <= ST_WOP;
        end
        ST_L2_A1: begin
          op_a <= res; op_b <= d_l; div_go <= 1'b1;
          ret_state <= ST_L2_A2; state <= ST_WOP;
        end
        ST_L2_A2: begin
          ca <= res;
          op_a <= w_r; op_b <= sat_sub(w_r, sat_add(u_r, u_r)); mul_go <= 1'b1;
          ret_state <= ST_L2_A3; state <= ST_WOP;
        end
        ST_L2_A3: begin
          op_a <= res; op_b <= d_r; div_go <= 1'b1;
          ret_state <= ST_L2_A4; state <= ST_WOP;
        end
        ST_L2_A4: begin
          cb <= res;
          op_a <= val_l; op_b <= sat_sub(w_l, u_l); mul_go <= 1'b1;
          ret_state <= ST_L2_A5; state <= ST_WOP;
        end
        ST_L2_A5: begin
          t1 <= res;
          op_a <= u_l; op_b <= w_l; mul_go <= 1'b1;
          ret_state <= ST_L2_A6; state <= ST_WOP;
        end
        ST_L2_A6: begin
          op_a <= t1; op_b <= res; div_go <= 1'b1;
          ret_state <= ST_L2_A7; state <= ST_WOP;
        end
        ST_L2_A7: begin
          kl <= res;
          op_a <= val_r; op_b <= sat_sub(w_r, u_r); mul_go <= 1'b1;
          ret_state <= ST_L2_A8; state <= ST_WOP;
        end
        ST_L2_A8: begin
          t1 <= res;
          op_a <= u_r; op_b <= w_r; mul_go <= 1'b1;
          ret_state <= ST_L2_A9; state <= ST_WOP;
        end
        ST_L2_A9: begin
          op_a <= t1; op_b <= res; div_go <= 1'b1;
          ret_state <= ST_L2_A10; state <= ST_WOP;
        end
        ST_L2_A10: begin
          kr <= sat_neg(res);
          op_a <= w_l; op_b <= w_l; mul_go <= 1'b1;
          ret_state <= ST_L2_A11; state <= ST_WOP;
        end
        ST_L2_A11: begin
          op_a <= res; op_b <= d_l; div_go <= 1'b1;
          ret_state <= ST_L2_A12; state <= ST_WOP;
        end
        ST_L2_A12: begin
          lo_c <= sat_neg(res);
          op_a <= u_r; op_b <= u_r; mul_go <= 1'b1;
          ret_state <= ST_L2_A13; state <= ST_WOP;
        end
        ST_L2_A13: begin
          op_a <= res; op_b <= d_r; div_go <= 1'b1;
          ret_state <= ST_L2_A14; state <= ST_WOP;
        end
        ST_L2_A14: begin
          up    <= sat_neg(res);
          dg    <= sat_sub(ca, cb);
          rr    <= sat_sub(kr, kl);
          state <= ST_L2_M0;
        end
        // The closing row comes from the right end condition.
        ST_L2_E0: begin
          lo_c <= sat_neg(w_l);
          dg   <= u_l;
          up   <= '0;
          op_a <= val_l; op_b <= sat_sub(u_l, w_l); mul_go <= 1'b1;
          ret_state <= ST_L2_E1; state <= ST_WOP;
        end
        ST_L2_E1: begin
          rr    <= res;
          state <= ST_L2_M0;
        end
        ST_L2_M0: begin
          op_a <= lo_c; op_b <= diag_p; div_go <= 1'b1;
          ret_state <= ST_L2_M1; state <= ST_WOP;
        end
        ST_L2_M1: begin
          t1 <= res;
          op_a <= res; op_b <= upper_p; mul_go <= 1'b1;
          ret_state <= ST_L2_M2; state <= ST_WOP;
        end
        ST_L2_M2: begin
          dg <= sat_sub(dg, res);
          op_a <= t1; op_b <= rhs_p; mul_go <= 1'b1;
          ret_state <= ST_L2_M3; state <= ST_WOP;
        end
        ST_L2_M3: begin
          rr    <= sat_sub(rr, res);
          state <= (idx == nact) ? ST_L2_F0 : ST_L2_W;
        end
        ST_L2_W: begin
          idx   <= idx + ONE;
          state <= ST_L2_R0;
        end
        ST_L2_F0: begin
          op_a <= rr; op_b <= dg; div_go <= 1'b1;
          ret_state <= ST_L2_F1; state <= ST_WOP;
        end
        ST_L2_F1: begin
          xr    <= res;
          idx   <= nm1;
          state <= ST_L3_R0;
        end

        // Pass three: back substitution from the last row back to row zero.
        ST_L3_R0: state <= ST_L3_R1;
        ST_L3_R1: begin
          diag_p <= diag_q;
          rhs_p  <= rhs_q;
          op_a <= upper_q; op_b <= xr; mul_go <= 1'b1;
          ret_state <= ST_L3_A; state <= ST_WOP;
        end
        ST_L3_A: begin
          op_a <= sat_sub(rhs_p, res); op_b <= diag_p; div_go <= 1'b1;
          ret_state <= ST_L3_B; state <= ST_WOP;
        end
        ST_L3_B: begin
          xr <= res;
          if (idx == '0) begin
            state <= ST_L4_R0;
          end else begin
            idx   <= idx - ONE;
            state <= ST_L3_R0;
          end
        end

        // Pass four: linear and quadratic coefficient of each piece.
        ST_L4_R0: state <= ST_L4_R1;
        ST_L4_R1: begin
          val_l <= to_fx(val_q);
          rhs_p <= rhs_q;
          u_l <= u_q; w_l <= w_q; d_l <= d_q;
          state <= ST_L4_R2;
        end
        ST_L4_R2: begin
          rhs_n <= rhs_q;
          state <= ST_L4_P;
        end
        ST_L4_P: begin
          d0    <= sat_sub(rhs_p, val_l);
          d1    <= sat_sub(rhs_n, val_l);
          state <= ST_L4_A0;
        end
        ST_L4_A0: begin
          op_a <= d0; op_b <= w_l; mul_go <= 1'b1;
          ret_state <= ST_L4_A1; state <= ST_WOP;
        end
        ST_L4_A1: begin
          op_a <= res; op_b <= w_l; mul_go <= 1'b1;
          ret_state <= ST_L4_A2; state <= ST_WOP;
        end
        ST_L4_A2: begin
          t1 <= res;
          op_a <= d1; op_b <= u_l; mul_go <= 1'b1;
          ret_state <= ST_L4_A3; state <= ST_WOP;
        end
        ST_L4_A3: begin
          op_a <= res; op_b <= u_l; mul_go <= 1'b1;
          ret_state <= ST_L4_A4; state <= ST_WOP;
        end
        ST_L4_A4: begin
          op_a <= sat_sub(t1, res); op_b <= d_l; div_go <= 1'b1;
          ret_state <= ST_L4_A5; state <= ST_WOP;
        end
        ST_L4_A5: begin
          op_a <= d1; op_b <= u_l; mul_go <= 1'b1;
          ret_state <= ST_L4_A6; state <= ST_WOP;
        end
        ST_L4_A6: begin
          t1 <= res;
          op_a <= d0; op_b <= w_l; mul_go <= 1'b1;
          ret_state <= ST_L4_A7; state <= ST_WOP;
        end
        ST_L4_A7: begin
          op_a <= sat_sub(t1, res); op_b <= d_l; div_go <= 1'b1;
          ret_state <= ST_L4_A8; state <= ST_WOP;
        end
        ST_L4_A8: begin
          if (idx == nm1) begin
            state <= ST_FIN;
          end else begin
            idx   <= idx + ONE;
            state <= ST_L4_R0;
          end
        end
        ST_FIN: begin
          built      <= !fault;
          res_status <= fault ? STATUS_DIV0 : STATUS_OK;
          state      <= ST_OUT;
        end

        // Query: clamp at the ends, binary search, the mid-point split, then the evaluation.
        ST_Q_R0: state <= ST_Q_R1;
        ST_Q_R1: begin
          pp    <= to_fx(pos_q);
          state <= ST_Q_R2;
        end
        ST_Q_R2: begin
          if (tq <= pp) begin
            idx   <= '0;
            state <= ST_E_R0;
          end else if (tq >= to_fx(pos_q)) begin
            idx   <= nm1;
            state <= ST_E_R0;
          end else begin
            lo    <= '0;
            hi    <= nm1;
            state <= ST_S_CHK;
          end
        end
        ST_S_CHK: state <= ((hi - lo) > ONE) ? ST_S_CMP : ST_S_SP0;
        ST_S_CMP: begin
          if (to_fx(pos_q) <= tq) lo <= mid;
          else hi <= mid;
          state <= ST_S_CHK;
        end
        ST_S_SP0: state <= ST_S_SP1;
        ST_S_SP1: begin
          pp    <= to_fx(pos_q);
          state <= ST_S_SP2;
        end
        ST_S_SP2: begin
          idx   <= (tq < (sat_add(pp, to_fx(pos_q)) >>> 1)) ? lo : lo + ONE;
          state <= ST_E_R0;
        end
        ST_E_R0: state <= ST_E_R1;
        ST_E_R1: begin
          val_l <= to_fx(val_q);
          pc    <= to_fx(pos_q);
          ca    <= lin_q;
          cb    <= quad_q;
          state <= ST_E_DX;
        end
        ST_E_DX: begin
          dx    <= sat_sub(tq, pc);
          state <= ST_E_M0;
        end
        ST_E_M0: begin
          op_a <= ca; op_b <= dx; mul_go <= 1'b1;
          ret_state <= ST_E_M1; state <= ST_WOP;
        end
        ST_E_M1: begin
          t1 <= res;
          op_a <= cb; op_b <= dx; mul_go <= 1'b1;
          ret_state <= ST_E_M2; state <= ST_WOP;
        end
        ST_E_M2: begin
          op_a <= res; op_b <= dx; mul_go <= 1'b1;
          ret_state <= ST_E_M3; state <= ST_WOP;
        end
        ST_E_M3: begin
          t2    <= res;
          rr    <= sat_add(val_l, t1);
          state <= ST_E_S;
        end
        ST_E_S: begin
          rr    <= sat_add(rr, t2);
          state <= ST_E_O;
        end
        ST_E_O: begin
          if (sh_out > FX32_MAX)      res_value <= 32'sh7FFF_FFFF;
          else if (sh_out < FX32_MIN) res_value <= 32'sh8000_0000;
          else                        res_value <= sh_out[31:0];
          res_status <= STATUS_OK;
          state      <= ST_OUT;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the quadratic spline fit and evaluation block.
`timescale 1ns / 1ps

module tb;
  import qsfe_pkg::*;

  // Mode three has no name in the package; the block takes it and does nothing.
  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam int NODES = 256;
  localparam int ITEM_TARGET = 1500;

  // Bit-exact copy of the spline arithmetic with its own node store, coefficients
  // and solver scratch, plus the queue of results that the block still owes.
  class spline_scoreboard;
    bit [31:0] pos_mem[NODES];
    bit [31:0] val_mem[NODES];
    longint c_lin[NODES];
    longint c_quad[NODES];
    longint diag[NODES+1];
    longint upper[NODES+1];
    longint rhs[NODES+1];
    longint su[NODES];
    longint sw[NODES];
    longint sd[NODES];
    int unsigned count;
    bit built;
    bit fault;
    out_item_t pending_results[$];
    int errors;

    function new();
      for (int i = 0; i < NODES; i++) begin
        pos_mem[i] = 0;
        val_mem[i] = 0;
      end
      count = 0;
      built = 0;
      fault = 0;
      errors = 0;
    endfunction

    function longint clamp_add(longint a, longint b);
      longint r;
      r = a + b;
      if (((a < 0) == (b < 0)) && ((r < 0) != (a < 0)))
        return (a < 0) ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      return r;
    endfunction

    function longint clamp_sub(longint a, longint b);
      longint r;
      r = a - b;
      if (((a < 0) != (b < 0)) && ((r < 0) != (a < 0)))
        return (a < 0) ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
      return r;
    endfunction

    function longint clamp_neg(longint a);
      return (a == 64'sh8000_0000_0000_0000) ? 64'sh7FFF_FFFF_FFFF_FFFF : -a;
    endfunction

    function bit [63:0] abs_of(longint a);
      bit [63:0] u;
      u = a;
      return (a < 0) ? (64'd0 - u) : u;
    endfunction

    function longint signed_of(bit [63:0] q, bit neg, bit ovf);
      if (neg) begin
        if (ovf || q > 64'h8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return longint'(64'd0 - q);
      end
      if (ovf || q[63]) return 64'sh7FFF_FFFF_FFFF_FFFF;
      return longint'(q);
    endfunction

    // Q32.32 product: full 128-bit magnitude, truncated toward zero.
    function longint fx_mult(longint a, longint b);
      bit [127:0] p;
      p = {64'd0, abs_of(a)} * {64'd0, abs_of(b)};
      return signed_of(p[95:32], (a < 0) != (b < 0), |p[127:96]);
    endfunction

    // Q32.32 quotient; a zero divisor gives zero and raises the fault.
    function longint fx_quot(longint a, longint b);
      bit [95:0] num;
      bit [95:0] q;
      if (b == 0) begin
        fault = 1;
        return 0;
      end
      num = {abs_of(a), 32'd0};
      q = num / {32'd0, abs_of(b)};
      return signed_of(q[63:0], (a < 0) != (b < 0), |q[95:64]);
    endfunction

    function longint to_fx(bit [31:0] raw);
      longint v;
      v = longint'($signed(raw));
      return v <<< 16;
    endfunction

    function longint px(int i);
      return to_fx(pos_mem[i]);
    endfunction

    function longint vx(int i);
      return to_fx(val_mem[i]);
    endfunction

    function int active();
      return (count > NODES) ? NODES : int'(count);
    endfunction

    // Knot j sits between nodes j-1 and j; the outer two are extrapolated.
    function longint knot_at(int j, int n);
      longint ext;
      if (j == 0) begin
        ext = clamp_sub(px(0), clamp_sub(px(1), px(0)));
        return clamp_add(ext, px(0)) >>> 1;
      end
      if (j == n) begin
        ext = clamp_add(px(n-1), clamp_sub(px(n-1), px(n-2)));
        return clamp_add(px(n-1), ext) >>> 1;
      end
      return clamp_add(px(j-1), px(j)) >>> 1;
    endfunction

    function logic [1:0] fit();
      int n;
      longint lo, dg, up, r, m, ul, wl, dl, ur, wr, dr, ca, cb, kl, kr;
      longint fi, d0, d1;
      n = active();
      built = 0;
      if (n < 3) return STATUS_FEW;
      fault = 0;
      for (int i = 0; i < n; i++) begin
        su[i] = clamp_sub(knot_at(i, n), px(i));
        sw[i] = clamp_sub(knot_at(i + 1, n), px(i));
        sd[i] = fx_mult(fx_mult(su[i], sw[i]), clamp_sub(sw[i], su[i]));
      end
      diag[0] = clamp_neg(sw[0]);
      upper[0] = su[0];
      rhs[0] = fx_mult(vx(0), clamp_sub(su[0], sw[0]));
      for (int j = 1; j <= n; j++) begin
        if (j < n) begin
          ul = su[j-1]; wl = sw[j-1]; dl = sd[j-1];
          ur = su[j];   wr = sw[j];   dr = sd[j];
          ca = fx_quot(fx_mult(ul, clamp_sub(clamp_add(wl, wl), ul)), dl);
          cb = fx_quot(fx_mult(wr, clamp_sub(wr, clamp_add(ur, ur))), dr);
          kl = fx_quot(fx_mult(vx(j-1), clamp_sub(wl, ul)), fx_mult(ul, wl));
          kr = clamp_neg(fx_quot(fx_mult(vx(j), clamp_sub(wr, ur)), fx_mult(ur, wr)));
          lo = clamp_neg(fx_quot(fx_mult(wl, wl), dl));
          dg = clamp_sub(ca, cb);
          up = clamp_neg(fx_quot(fx_mult(ur, ur), dr));
          r = clamp_sub(kr, kl);
        end else begin
          lo = clamp_neg(sw[n-1]);
          dg = su[n-1];
          up = 0;
          r = fx_mult(vx(n-1), clamp_sub(su[n-1], sw[n-1]));
        end
        m = fx_quot(lo, diag[j-1]);
        diag[j] = clamp_sub(dg, fx_mult(m, upper[j-1]));
        upper[j] = up;
        rhs[j] = clamp_sub(r, fx_mult(m, rhs[j-1]));
      end
      rhs[n] = fx_quot(rhs[n], diag[n]);
      for (int j = n - 1; j >= 0; j--)
        rhs[j] = fx_quot(clamp_sub(rhs[j], fx_mult(upper[j], rhs[j+1])), diag[j]);
      for (int i = 0; i < n; i++) begin
        fi = vx(i);
        d0 = clamp_sub(rhs[i], fi);
        d1 = clamp_sub(rhs[i+1], fi);
        c_lin[i] = fx_quot(clamp_sub(fx_mult(fx_mult(d0, sw[i]), sw[i]),
                                     fx_mult(fx_mult(d1, su[i]), su[i])), sd[i]);
        c_quad[i] = fx_quot(clamp_sub(fx_mult(d1, su[i]), fx_mult(d0, sw[i])), sd[i]);
      end
      if (fault) return STATUS_DIV0;
      built = 1;
      return STATUS_OK;
    endfunction

    // Binary search for the bracketing pair, then split at its mid-point.
    function int piece_of(longint t, int n);
      int lo, hi, mid;
      lo = 0;
      hi = n - 1;
      if (t <= px(0)) return 0;
      if (t >= px(n-1)) return n - 1;
      while (hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (px(mid) <= t) lo = mid;
        else hi = mid;
      end
      if (t < (clamp_add(px(lo), px(lo + 1)) >>> 1)) return lo;
      return lo + 1;
    endfunction

    function void note_count(int unsigned v);
      count = v & 9'h1FF;
      built = 0;
    endfunction

    function void note_transfer(in_item_t it);
      out_item_t res;
      int n, k;
      longint t, dx, r, v;
      res.value = 0;
      res.status = STATUS_OK;
      case (it.mode)
        MODE_LOAD: begin
          pos_mem[it.node_index] = it.node_pos;
          val_mem[it.node_index] = it.node_val;
          built = 0;
        end
        MODE_BUILD: begin
          res.status = fit();
          pending_results.push_back(res);
        end
        MODE_EVAL: begin
          n = active();
          if (n < 3) res.status = STATUS_FEW;
          else if (!built) res.status = STATUS_UNBUILT;
          else begin
            t = to_fx(it.query_pos);
            k = piece_of(t, n);
            dx = clamp_sub(t, px(k));
            r = clamp_add(clamp_add(vx(k), fx_mult(c_lin[k], dx)),
                          fx_mult(fx_mult(c_quad[k], dx), dx));
            v = r >>> 16;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            res.value = v[31:0];
          end
          pending_results.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_transfer(out_item_t got);
      out_item_t exp;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d", $time, got.value, got.status);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.value !== exp.value) begin
        $display("%0t: value mismatch expected %h actual %h", $time, exp.value, got.value);
        errors++;
      end
      if (got.status !== exp.status) begin
        $display("%0t: status mismatch expected %0d actual %0d", $time, exp.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_write_en = 0;
  logic [CFG_W-1:0] cfg_write_data = '0;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_data;

  spline_scoreboard sb = new();

  // Idle odds in percent for the sender and the receiver; they change with progress.
  int tx_idle_pct = 7;
  int rx_stall_pct = 77;
  int items_sent = 0;
  // Positions loaded in the current set, used to aim queries near the nodes.
  logic [31:0] set_pos[NODES];
  int set_n = 0;

  quadratic_spline_fit_eval u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // The receiver decides its stall for the coming edge at each falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // Every accepted result transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_transfer(out_data);
  end

  // Offers one item, holds it steady through stalls, and records it once accepted.
  task automatic send_item(in_item_t it);
    // The idle odds follow the thirds of the run: receiver slow, then sender
    // slow, then both at full speed.
    if (items_sent < ITEM_TARGET / 3) begin
      tx_idle_pct = 7;
      rx_stall_pct = 77;
    end else if (items_sent < 2 * ITEM_TARGET / 3) begin
      tx_idle_pct = 77;
      rx_stall_pct = 7;
    end else begin
      tx_idle_pct = 0;
      rx_stall_pct = 0;
    end
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_transfer(it);
    items_sent++;
  endtask

  function automatic in_item_t noise_fields();
    in_item_t it;
    it.mode = MODE_NOP;
    it.node_index = 8'($urandom);
    it.node_pos = $urandom;
    it.node_val = $urandom;
    it.query_pos = $urandom;
    return it;
  endfunction

  task automatic load_node(int idx, logic [31:0] p, logic [31:0] v);
    in_item_t it;
    it = noise_fields();
    it.mode = MODE_LOAD;
    it.node_index = 8'(idx);
    it.node_pos = p;
    it.node_val = v;
    if (idx < NODES) set_pos[idx] = p;
    send_item(it);
  endtask

  task automatic query_at(logic [31:0] t);
    in_item_t it;
    it = noise_fields();
    it.mode = MODE_EVAL;
    it.query_pos = t;
    send_item(it);
  endtask

  task automatic start_fit();
    in_item_t it;
    it = noise_fields();
    it.mode = MODE_BUILD;
    send_item(it);
  endtask

  // Drains the block: no item on offer, every result in, then a short margin
  // for a load that may still be settling.
  task automatic settle();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_count(int unsigned v);
    settle();
    @(negedge clk);
    cfg_write_en <= 1;
    cfg_write_data <= CFG_W'(v);
    @(posedge clk);
    sb.note_count(v);
    @(negedge clk);
    cfg_write_en <= 0;
  endtask

  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(3) != 0) v = $signed(v) >>> $urandom_range(4, 20);
    return v;
  endfunction

  // Loads slots 0..n-1. Flavors: 0 ascending, 1 ascending with repeats,
  // 2 unsorted, 3 ascending with huge spacings near the ends of the range.
  task automatic load_set(int n, int flavor, int span_bits);
    longint p, step;
    p = longint'($signed(32'($urandom))) >>> $urandom_range(4, 16);
    if (flavor == 3) p = -64'sd2147483648 + $urandom_range(0, 1000);
    for (int i = 0; i < n; i++) begin
      load_node(i, p[31:0], rand_value());
      case (flavor)
        1: step = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 1 << span_bits);
        2: step = longint'($signed(32'($urandom))) >>> $urandom_range(0, 12);
        3: step = longint'($urandom_range(1, 32'h7FFF_FFFF)) * 2;
        default: step = $urandom_range(1, 1 << span_bits);
      endcase
      p = p + step;
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      // Now and then slip in an item that leaves the set alone.
      if ($urandom_range(19) == 0) begin
        if (n < NODES && $urandom_range(1) == 0)
          load_node($urandom_range(n, NODES - 1), $urandom, $urandom);
        else
          send_item(noise_fields());
      end
    end
  endtask

  function automatic logic [31:0] pick_query();
    longint t;
    int k;
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: t = longint'($signed(set_pos[0])) - $urandom_range(0, 1 << 20);
      3: t = longint'($signed(set_pos[set_n - 1])) + $urandom_range(0, 1 << 20);
      default: begin
        k = $urandom_range(0, set_n - 1);
        t = longint'($signed(set_pos[k]))
            + (longint'($signed(32'($urandom))) >>> $urandom_range(8, 24));
      end
    endcase
    return t[31:0];
  endfunction

  // One fit: count write, an occasional early query, node set, build, then queries
  // with an occasional reload of a slot that forces a rebuild.
  task automatic run_fit(int unsigned cfg, int flavor, int span_bits, int queries);
    int n, k;
    n = (cfg > NODES) ? NODES : cfg;
    set_count(cfg);
    set_n = (n > 0) ? n : 1;
    if (n == 0) set_pos[0] = 0;
    if ($urandom_range(3) == 0) query_at($urandom);
    load_set(n, flavor, span_bits);
    start_fit();
    for (int q = 0; q < queries; q++) begin
      query_at(pick_query());
      if (n > 0 && $urandom_range(39) == 0) begin
        k = $urandom_range(0, n - 1);
        load_node(k, set_pos[k], rand_value());
        query_at(pick_query());
        start_fit();
      end
    end
  endtask

  initial begin
    int unsigned cfg;
    int flavor;
    repeat (5) @(negedge clk);
    rst <= 0;

    // No nodes in use yet: build and query both report too few nodes.
    set_n = 1;
    set_pos[0] = 0;
    query_at(32'h1234_5678);
    start_fit();
    send_item(noise_fields());

    // Three nodes at the extremes of position and value; query before the build
    // reports not built, then the extremes of t and the interior.
    set_count(3);
    load_node(0, 32'h8000_0000, 32'h7FFF_FFFF);
    load_node(1, 32'h0000_0000, 32'h8000_0000);
    load_node(2, 32'h7FFF_FFFF, 32'h0000_0000);
    query_at(32'h0);
    start_fit();
    query_at(32'h8000_0000);
    query_at(32'h7FFF_FFFF);
    query_at(32'h0);
    query_at(32'h4000_0000);
    load_node(255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Repeated positions divide by zero; the block stays unbuilt afterwards.
    set_count(3);
    load_node(0, 32'h000A_0000, 32'h0001_0000);
    load_node(1, 32'h000A_0000, 32'h0002_0000);
    load_node(2, 32'h0014_0000, 32'h0003_0000);
    start_fit();
    query_at(32'h000C_0000);

    // A small well-behaved fit.
    set_count(4);
    set_n = 4;
    for (int i = 0; i < 4; i++) load_node(i, i << 16, (i * i) << 16);
    start_fit();
    query_at(32'h0001_8000);

    // The widest count: every slot in use, moderate spacing so the build is sound.
    run_fit(511, 0, 14, 30);

    // Random fits, mostly small since a build is slow per node.
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(19))
        0: cfg = $urandom_range(0, 2);
        1: cfg = $urandom_range(9, 16);
        default: cfg = $urandom_range(3, 8);
      endcase
      case ($urandom_range(9))
        0: flavor = 1;
        1: flavor = 2;
        2: flavor = 3;
        default: flavor = 0;
      endcase
      run_fit(cfg, flavor, $urandom_range(4, 26), $urandom_range(10, 40));
    end

    settle();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run including the full-size builds.
  initial begin
    #300_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
